// ----- rtl/core/pbu_pkg.sv -----
// Shared types and constants for the phased barrier unit.
// Request kinds, status codes and the result record used by the core and top level.
// No dependencies.
package pbu_pkg;

    // default parameter values
    localparam int unsigned MAX_PARTY_DEF  = 255;
    localparam int unsigned PHASE_BITS_DEF = 16;

    // field widths fixed by the interface
    localparam int unsigned KIND_W   = 3;
    localparam int unsigned PHASE_W  = 16;
    localparam int unsigned PARTY_W  = 8;
    localparam int unsigned STATUS_W = 3;

    // request kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_INIT          = 3'd0,
        KIND_ARRIVE        = 3'd1,
        KIND_POLL          = 3'd2,
        KIND_ARRIVE_DETACH = 3'd3,
        KIND_DETACH_EXCEPT = 3'd4,
        KIND_ATTACH        = 3'd5,
        KIND_DETACH        = 3'd6
    } kind_t;

    // status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_STATIC   = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_MISMATCH = 3'd3,
        ST_SAT      = 3'd4
    } status_t;

    // one result beat
    typedef struct packed {
        status_t              status;
        logic [PARTY_W-1:0]   party_now;
        logic [PHASE_W-1:0]   phase_now;
        logic                 last_one;
        logic                 elected;
        logic                 released;
    } result_t;

endpackage

// ----- rtl/core/phased_barrier_unit_top.sv -----
// Top level of the phased barrier unit: stream request and result channels.
// Input register, barrier core and result register; depends on pbu_pkg and pbu_core.
//
//  channel   direction  ports                          content
//  s_*       in         s_tvalid s_tready s_tdata s_tuser   request beat
//  m_*       out        m_tvalid m_tready m_tdata          result beat
//  cfg_*     in         cfg_wen cfg_wdata                  party_size register
//
// An accepted request beat passes through the input register, where the core updates the
// barrier state, and then the result register, from which its result beat is taken.
// One request per cycle is accepted while m_tready is high; while a finished result waits,
// the input register takes at most one more beat and then holds until m_tready returns.
// rst_n clears the valid flags, the barrier state and party_size asynchronously.
module phased_barrier_unit_top #(
    parameter int unsigned MAX_PARTY  = pbu_pkg::MAX_PARTY_DEF,
    parameter int unsigned PHASE_BITS = pbu_pkg::PHASE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] poll_phase
    input  logic [2:0]  s_tuser,   // [2:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [0] released, [1] elected, [2] last_one,
                                   // [18:3] phase_now, [26:19] party_now,
                                   // [29:27] status, [31:30] zero
    input  logic        cfg_wen,
    input  logic [7:0]  cfg_wdata
);

    logic                        in_valid_reg;
    pbu_pkg::kind_t              in_kind_reg;
    logic [pbu_pkg::PHASE_W-1:0] in_start_reg;
    logic                        out_valid_reg;
    pbu_pkg::result_t            out_res_reg;
    pbu_pkg::result_t            step_res;
    logic                        advance;

    // the input beat moves on when the result register is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_kind_reg  <= pbu_pkg::kind_t'(s_tuser);
            in_start_reg <= s_tdata;
        end
    end

    // barrier state and update logic
    pbu_core #(
        .MAX_PARTY  (MAX_PARTY),
        .PHASE_BITS (PHASE_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata),
        .step_en     (advance),
        .step_kind   (in_kind_reg),
        .step_start  (in_start_reg),
        .step_result (step_res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_res_reg <= step_res;
    end

    // result beat packing
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_res_reg};

endmodule

// ----- rtl/core/pbu_core.sv -----
// Barrier state and per-request update logic of the phased barrier unit.
// Holds party, arrival, phase and election state plus the party_size register.
// Depends on pbu_pkg.
module pbu_core #(
    parameter int unsigned MAX_PARTY  = pbu_pkg::MAX_PARTY_DEF,
    parameter int unsigned PHASE_BITS = pbu_pkg::PHASE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wen,
    input  logic [pbu_pkg::PARTY_W-1:0]  cfg_wdata,
    input  logic                         step_en,
    input  pbu_pkg::kind_t               step_kind,
    input  logic [pbu_pkg::PHASE_W-1:0]  step_start,
    output pbu_pkg::result_t             step_result
);

    localparam int unsigned PLIM = (MAX_PARTY < 255) ? MAX_PARTY : 255;
    localparam logic [pbu_pkg::PARTY_W-1:0] PARTY_LIMIT = pbu_pkg::PARTY_W'(PLIM);

    logic [pbu_pkg::PARTY_W-1:0] party_size_reg;
    logic [pbu_pkg::PARTY_W-1:0] party_reg, party_next;
    logic [pbu_pkg::PARTY_W-1:0] arrival_reg, arrival_next;
    logic [PHASE_BITS-1:0]       phase_reg, phase_next;
    logic [PHASE_BITS-1:0]       elect_reg, elect_next;
    logic                        fixed_reg, fixed_next;

    logic [PHASE_BITS+pbu_pkg::PHASE_W-1:0] start_ext;
    logic [PHASE_BITS+pbu_pkg::PHASE_W-1:0] phase_ext;
    logic [PHASE_BITS-1:0]                  start_m;
    logic [PHASE_BITS-1:0]                  start_inc;
    logic [PHASE_BITS-1:0]                  phase_inc;
    logic [pbu_pkg::PARTY_W:0]              arr_inc;
    logic [pbu_pkg::PARTY_W-1:0]            party_dec;
    logic                                   rel, elect, last;
    pbu_pkg::status_t                       status;

    // start phase taken modulo the phase range
    assign start_ext = {{PHASE_BITS{1'b0}}, step_start};
    assign start_m   = start_ext[PHASE_BITS-1:0];
    assign start_inc = start_m + 1'b1;
    assign phase_inc = phase_reg + 1'b1;
    assign arr_inc   = {1'b0, arrival_reg} + 1'b1;
    assign party_dec = party_reg - 1'b1;

    // next state and result for the request in the input register
    always_comb
    begin
        party_next   = party_reg;
        arrival_next = arrival_reg;
        phase_next   = phase_reg;
        elect_next   = elect_reg;
        fixed_next   = fixed_reg;
        rel          = 1'b0;
        elect        = 1'b0;
        last         = 1'b0;
        status       = pbu_pkg::ST_OK;
        unique case (step_kind)
            pbu_pkg::KIND_INIT:
            begin
                if (party_size_reg > PARTY_LIMIT)
                begin
                    party_next = PARTY_LIMIT;
                    status     = pbu_pkg::ST_SAT;
                end
                else
                begin
                    party_next = party_size_reg;
                end
                arrival_next = '0;
                phase_next   = '0;
                elect_next   = '0;
                fixed_next   = (party_size_reg != '0);
            end
            pbu_pkg::KIND_ARRIVE:
            begin
                if (party_reg == '0)
                begin
                    status = pbu_pkg::ST_EMPTY;
                end
                else if (arr_inc >= {1'b0, party_reg})
                begin
                    arrival_next = '0;
                    phase_next   = phase_inc;
                    elect_next   = phase_inc;
                    rel          = 1'b1;
                    elect        = 1'b1;
                end
                else
                begin
                    arrival_next = arr_inc[pbu_pkg::PARTY_W-1:0];
                end
            end
            pbu_pkg::KIND_POLL:
            begin
                if (phase_reg == start_inc)
                begin
                    rel = 1'b1;
                    if (elect_reg != phase_reg)
                    begin
                        elect_next = phase_reg;
                        elect      = 1'b1;
                    end
                end
                else if (phase_reg != start_m)
                begin
                    status = pbu_pkg::ST_MISMATCH;
                end
            end
            pbu_pkg::KIND_ARRIVE_DETACH, pbu_pkg::KIND_DETACH:
            begin
                if (fixed_reg)
                begin
                    status = pbu_pkg::ST_STATIC;
                end
                else if (party_reg == '0)
                begin
                    status = pbu_pkg::ST_EMPTY;
                end
                else
                begin
                    party_next = party_dec;
                    // a plain detach of the last member leaves the phase alone
                    if ((step_kind == pbu_pkg::KIND_ARRIVE_DETACH || party_dec != '0)
                        && arrival_reg >= party_dec)
                    begin
                        rel          = 1'b1;
                        arrival_next = '0;
                        phase_next   = phase_inc;
                    end
                    last = (party_dec == '0);
                end
            end
            pbu_pkg::KIND_DETACH_EXCEPT:
            begin
                if (party_reg == '0)
                begin
                    status = pbu_pkg::ST_EMPTY;
                end
                else if (party_reg > 8'd1)
                begin
                    party_next = party_dec;
                end
                else
                begin
                    phase_next = phase_inc;
                    rel        = 1'b1;
                    last       = 1'b1;
                end
            end
            pbu_pkg::KIND_ATTACH:
            begin
                if (fixed_reg)
                    status = pbu_pkg::ST_STATIC;
                else if (party_reg >= PARTY_LIMIT)
                    status = pbu_pkg::ST_SAT;
                else
                    party_next = party_reg + 1'b1;
            end
            default:
            begin
                // unused kind: report state only
            end
        endcase
    end

    // result fields
    assign phase_ext = {{pbu_pkg::PHASE_W{1'b0}}, phase_next};
    always_comb
    begin
        step_result.released  = rel;
        step_result.elected   = elect;
        step_result.last_one  = last;
        step_result.phase_now = phase_ext[pbu_pkg::PHASE_W-1:0];
        step_result.party_now = party_next;
        step_result.status    = status;
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            party_size_reg <= '0;
        else if (cfg_wen)
            party_size_reg <= cfg_wdata;
    end

    // barrier state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            party_reg   <= '0;
            arrival_reg <= '0;
            phase_reg   <= '0;
            elect_reg   <= '0;
            fixed_reg   <= 1'b0;
        end
        else if (step_en)
        begin
            party_reg   <= party_next;
            arrival_reg <= arrival_next;
            phase_reg   <= phase_next;
            elect_reg   <= elect_next;
            fixed_reg   <= fixed_next;
        end
    end

endmodule

// ----- rtl/core/pbu_checker.sv -----
// Port-level checks for the phased barrier unit, bound to the top level.
// Looks at the result channel only; takes the status codes from pbu_pkg.
module pbu_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // election only comes with a release
    a_elect: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1] |-> m_tdata[0])
        else $error("elected without release");

    // an error status never releases or reports a last member
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[29:27] != pbu_pkg::ST_OK |-> !m_tdata[0] && !m_tdata[2])
        else $error("release or last flag with error status");

    // status code and padding in range
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[31:30] == 2'b00 && m_tdata[29:27] <= pbu_pkg::ST_SAT)
        else $error("bad status code or padding");

endmodule

bind phased_barrier_unit_top pbu_checker u_pbu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for phased_barrier_unit_top: a directed opening, then random
// request streams over several party_size settings, checked against an in-bench barrier model.
// Depends on pbu_pkg and the phased_barrier_unit_top RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // kind seven is not decoded by the block
    localparam logic [pbu_pkg::KIND_W-1:0] KIND_SPARE = 3'd7;
    localparam int unsigned GROUP_CAP =
        (pbu_pkg::MAX_PARTY_DEF < 255) ? pbu_pkg::MAX_PARTY_DEF : 255;

    typedef struct packed {
        logic [pbu_pkg::KIND_W-1:0]  kind;
        logic [pbu_pkg::PHASE_W-1:0] start;
    } request_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;      // [15:0] poll_phase
    logic [2:0]  s_tuser = '0;      // [2:0] kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [0] released, [1] elected, [2] last_one,
                                    // [18:3] phase_now, [26:19] party_now, [29:27] status
    logic        cfg_wen = 1'b0;
    logic [7:0]  cfg_wdata = '0;

    // barrier model state
    logic [7:0]   cfg_party_size = '0;
    logic [7:0]   members = '0;
    int unsigned  arrivals = 0;
    logic [15:0]  phase_no = '0;
    logic [15:0]  elected_no = '0;
    logic         fixed_group = 1'b0;

    request_t          request_q[$];
    pbu_pkg::result_t  results_due[$];
    int           requests_posted = 0;
    int           requests_taken = 0;
    int           results_seen = 0;
    int           releases_seen = 0;
    int           elections_seen = 0;
    int           cfg_writes = 0;
    int           errors = 0;
    bit           beat_taken = 1'b0;
    bit           no_idle = 1'b0;
    int           send_gap = 0;
    int           stall_left = 0;

    phased_barrier_unit_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    // a participant leaves; with arrival it also counts towards the current phase
    function automatic void leave_group(input bit arrived, inout pbu_pkg::result_t r);
        if (fixed_group)
        begin
            r.status = pbu_pkg::ST_STATIC;
        end
        else if (members == 0)
        begin
            r.status = pbu_pkg::ST_EMPTY;
        end
        else
        begin
            members = members - 8'd1;
            if ((arrived || members > 0) && arrivals >= members)
            begin
                r.released = 1'b1;
                arrivals = 0;
                phase_no = phase_no + 16'd1;
            end
            r.last_one = (members == 0);
        end
    endfunction

    // one request against the barrier state, giving the result beat it must produce
    function automatic pbu_pkg::result_t barrier_step(
        input logic [pbu_pkg::KIND_W-1:0] kind,
        input logic [pbu_pkg::PHASE_W-1:0] start);
        pbu_pkg::result_t r;
        r = '0;
        case (kind)
            pbu_pkg::KIND_INIT:
            begin
                if (cfg_party_size > GROUP_CAP)
                begin
                    members = 8'(GROUP_CAP);
                    r.status = pbu_pkg::ST_SAT;
                end
                else
                begin
                    members = cfg_party_size;
                end
                arrivals = 0;
                phase_no = '0;
                elected_no = '0;
                fixed_group = (cfg_party_size != 0);
            end
            pbu_pkg::KIND_ARRIVE:
            begin
                if (members == 0)
                begin
                    r.status = pbu_pkg::ST_EMPTY;
                end
                else
                begin
                    arrivals++;
                    if (arrivals >= members)
                    begin
                        arrivals = 0;
                        phase_no = phase_no + 16'd1;
                        elected_no = phase_no;
                        r.released = 1'b1;
                        r.elected = 1'b1;
                    end
                end
            end
            pbu_pkg::KIND_POLL:
            begin
                if (phase_no == start + 16'd1)
                begin
                    r.released = 1'b1;
                    if (elected_no != phase_no)
                    begin
                        elected_no = phase_no;
                        r.elected = 1'b1;
                    end
                end
                else if (phase_no != start)
                begin
                    r.status = pbu_pkg::ST_MISMATCH;
                end
            end
            pbu_pkg::KIND_ARRIVE_DETACH:
            begin
                leave_group(1'b1, r);
            end
            pbu_pkg::KIND_DETACH_EXCEPT:
            begin
                if (members == 0)
                begin
                    r.status = pbu_pkg::ST_EMPTY;
                end
                else if (members > 1)
                begin
                    members = members - 8'd1;
                end
                else
                begin
                    phase_no = phase_no + 16'd1;
                    r.released = 1'b1;
                    r.last_one = 1'b1;
                end
            end
            pbu_pkg::KIND_ATTACH:
            begin
                if (fixed_group)
                    r.status = pbu_pkg::ST_STATIC;
                else if (members >= GROUP_CAP)
                    r.status = pbu_pkg::ST_SAT;
                else
                    members = members + 8'd1;
            end
            pbu_pkg::KIND_DETACH:
            begin
                leave_group(1'b0, r);
            end
            default:
            begin
            end
        endcase
        r.phase_now = phase_no;
        r.party_now = members;
        return r;
    endfunction

    // request driver: next beat once the current one is taken, with random gaps
    always @(negedge clk)
    begin
        request_t req;
        if (rst_n && (!s_tvalid || beat_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (request_q.size() > 0)
            begin
                req = request_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= req.kind;
                s_tdata <= req.start;
                if (!no_idle && $urandom_range(0, 9) == 0)
                    send_gap = $urandom_range(1, 11);
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side back-pressure in bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if (!no_idle && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 11);
        end
    end

    // monitor: check result beats, then predict for accepted request beats
    always @(posedge clk)
    begin
        pbu_pkg::result_t got;
        pbu_pkg::result_t want;
        beat_taken = 1'b0;
        if (rst_n)
        begin
            if (cfg_wen)
                cfg_party_size = cfg_wdata;
            if (m_tvalid && m_tready)
            begin
                got = pbu_pkg::result_t'(m_tdata[29:0]);
                results_seen++;
                if (results_due.size() == 0)
                begin
                    if (errors < 10)
                        $display("result %0d arrived with nothing outstanding: %h",
                                 results_seen, m_tdata);
                    errors++;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (got.released !== want.released || got.elected !== want.elected ||
                        got.last_one !== want.last_one || got.phase_now !== want.phase_now ||
                        got.party_now !== want.party_now || got.status !== want.status ||
                        m_tdata[31:30] !== 2'b00)
                    begin
                        if (errors < 10)
                            $display({"result %0d: want rel %b el %b last %b phase %h ",
                                      "party %0d st %0d / got rel %b el %b last %b phase %h ",
                                      "party %0d st %0d pad %b"}, results_seen,
                                     want.released, want.elected, want.last_one,
                                     want.phase_now, want.party_now, want.status,
                                     got.released, got.elected, got.last_one,
                                     got.phase_now, got.party_now, got.status,
                                     m_tdata[31:30]);
                        errors++;
                    end
                    if (want.released)
                        releases_seen++;
                    if (want.elected)
                        elections_seen++;
                end
            end
            if (s_tvalid && s_tready)
            begin
                beat_taken = 1'b1;
                requests_taken++;
                results_due.push_back(barrier_step(s_tuser, s_tdata));
            end
        end
    end

    // keep the request queue shallow so polls see a recent phase
    task automatic post_request(input logic [pbu_pkg::KIND_W-1:0] kind,
                                input logic [pbu_pkg::PHASE_W-1:0] start);
        while (request_q.size() >= 2)
            @(negedge clk);
        request_q.push_back('{kind: kind, start: start});
        requests_posted++;
    endtask

    task automatic wait_settled();
        while (requests_taken != requests_posted || results_due.size() != 0)
            @(negedge clk);
    endtask

    // register write only with the block drained
    task automatic set_party_size(input logic [7:0] size);
        wait_settled();
        @(negedge clk);
        cfg_wen <= 1'b1;
        cfg_wdata <= size;
        @(negedge clk);
        cfg_wen <= 1'b0;
        cfg_writes++;
    endtask

    // kind mix: mostly arrivals and polls, topping up a small dynamic group
    function automatic logic [pbu_pkg::KIND_W-1:0] pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (!fixed_group && members < 3 && r < 40)
            return pbu_pkg::KIND_ATTACH;
        if (r < 40)
            return pbu_pkg::KIND_ARRIVE;
        if (r < 60)
            return pbu_pkg::KIND_POLL;
        if (r < 68)
            return pbu_pkg::KIND_ATTACH;
        if (r < 75)
            return pbu_pkg::KIND_DETACH;
        if (r < 82)
            return pbu_pkg::KIND_ARRIVE_DETACH;
        if (r < 90)
            return pbu_pkg::KIND_DETACH_EXCEPT;
        if (r < 96)
            return pbu_pkg::KIND_INIT;
        return KIND_SPARE;
    endfunction

    task automatic run_phase(input logic [7:0] size, input int count, input bit fill_up);
        logic [pbu_pkg::KIND_W-1:0]  k;
        logic [pbu_pkg::PHASE_W-1:0] start;
        int                          r;
        set_party_size(size);
        post_request(pbu_pkg::KIND_INIT, 16'($urandom_range(0, 65535)));
        // push a dynamic group past its limit
        if (fill_up)
        begin
            for (int i = 0; i < 256; i++)
                post_request(pbu_pkg::KIND_ATTACH, 16'($urandom_range(0, 65535)));
        end
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 49) == 0)
                wait_settled();
            k = pick_kind();
            r = $urandom_range(0, 9);
            if (k == pbu_pkg::KIND_POLL && r < 4)
                start = phase_no;
            else if (k == pbu_pkg::KIND_POLL && r < 8)
                start = phase_no - 16'd1;
            else
                start = 16'($urandom_range(0, 65535));
            post_request(k, start);
        end
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // dynamic group: empty cases, spare kind, poll across the phase wrap
        set_party_size(8'd0);
        post_request(pbu_pkg::KIND_ARRIVE, 16'h0000);
        post_request(pbu_pkg::KIND_DETACH, 16'hffff);
        post_request(pbu_pkg::KIND_DETACH_EXCEPT, 16'h0000);
        post_request(pbu_pkg::KIND_ARRIVE_DETACH, 16'hffff);
        post_request(KIND_SPARE, 16'hffff);
        post_request(pbu_pkg::KIND_POLL, 16'hffff);
        repeat (3) post_request(pbu_pkg::KIND_ATTACH, 16'h0000);
        post_request(pbu_pkg::KIND_ARRIVE, 16'h0000);
        post_request(pbu_pkg::KIND_ARRIVE, 16'h0000);
        post_request(pbu_pkg::KIND_POLL, 16'h0000);
        post_request(pbu_pkg::KIND_POLL, 16'h1234);
        // detach leaves only arrived members: release by detach, then first poller elected
        post_request(pbu_pkg::KIND_DETACH, 16'h0000);
        post_request(pbu_pkg::KIND_POLL, 16'h0000);
        post_request(pbu_pkg::KIND_POLL, 16'h0000);
        post_request(pbu_pkg::KIND_ARRIVE_DETACH, 16'h0000);
        post_request(pbu_pkg::KIND_ARRIVE, 16'h0000);
        post_request(pbu_pkg::KIND_DETACH_EXCEPT, 16'h0000);
        post_request(pbu_pkg::KIND_ATTACH, 16'h0000);
        post_request(pbu_pkg::KIND_DETACH_EXCEPT, 16'h0000);
        post_request(pbu_pkg::KIND_ARRIVE_DETACH, 16'h0000);

        // full static group: misuse of attach and detach
        set_party_size(8'd255);
        post_request(pbu_pkg::KIND_INIT, 16'h0000);
        post_request(pbu_pkg::KIND_ATTACH, 16'h0000);
        post_request(pbu_pkg::KIND_DETACH, 16'h0000);
        post_request(pbu_pkg::KIND_ARRIVE_DETACH, 16'h0000);
        post_request(pbu_pkg::KIND_DETACH_EXCEPT, 16'h0000);
        post_request(pbu_pkg::KIND_INIT, 16'hffff);

        // random streams over several group sizes
        run_phase(8'd3, 70, 1'b0);
        run_phase(8'd0, 60, 1'b1);
        run_phase(8'd1, 60, 1'b0);
        run_phase(8'd5, 80, 1'b0);
        run_phase(8'd255, 40, 1'b0);
        run_phase(8'd2, 70, 1'b0);
        run_phase(8'd0, 80, 1'b0);
        no_idle = 1'b1;
        run_phase(8'd4, 70, 1'b0);

        wait_settled();
        repeat (6) @(negedge clk);
        if (results_due.size() != 0)
            errors += results_due.size();
        $display("%0d requests sent over %0d party_size writes, %0d results checked",
                 requests_taken, cfg_writes, results_seen);
        $display("%0d phase releases and %0d elections among them, %0d mismatches",
                 releases_seen, elections_seen, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // run limit
    initial
    begin
        #400000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
